// ----- src/table_capacity_grow_shrink_policy_assert.svh -----
// Assertion macros used by the checker file of the capacity policy block.
`ifndef TABLE_CAPACITY_GROW_SHRINK_POLICY_ASSERT_SVH
`define TABLE_CAPACITY_GROW_SHRINK_POLICY_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, muted during reset.
`define TCGS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("capacity policy assertion failed");

// Next-cycle implication, sampled on the rising clock, muted during reset.
`define TCGS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("capacity policy assertion failed");

`endif

// ----- src/tcgs_pkg.sv -----
// Types, constants and helper functions of the table capacity policy block.
package tcgs_pkg;

	localparam int CAP_W = 24;
	localparam int CNT_W = 32;
	localparam int THR_W = 9;
	localparam int FAC_W = 8;
	localparam int OP_W = 2;
	localparam int IDX_W = 3;

	localparam logic [OP_W-1:0] OP_GROW = 2'd0;
	localparam logic [OP_W-1:0] OP_SHRINK = 2'd1;
	localparam logic [OP_W-1:0] OP_PEAK = 2'd2;

	localparam logic [IDX_W-1:0] REG_INIT_CAP = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_CAP = 3'd1;
	localparam logic [IDX_W-1:0] REG_GROW_THR = 3'd2;
	localparam logic [IDX_W-1:0] REG_SHRINK_THR = 3'd3;
	localparam logic [IDX_W-1:0] REG_GROW_FAC = 3'd4;
	localparam logic [IDX_W-1:0] REG_SHRINK_FAC = 3'd5;

	localparam logic [CAP_W-1:0] INIT_CAP_RST = 24'd80000;
	localparam logic [CAP_W-1:0] MAX_CAP_RST = 24'd262144;
	localparam logic [THR_W-1:0] GROW_THR_RST = 9'd192;
	localparam logic [THR_W-1:0] SHRINK_THR_RST = 9'd64;
	localparam logic [FAC_W-1:0] GROW_FAC_RST = 8'd32;
	localparam logic [FAC_W-1:0] SHRINK_FAC_RST = 8'd128;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [CAP_W-1:0] live_count;
		logic resize_ok;
	} item_t;

	typedef struct packed {
		logic resized;
		logic [CAP_W-1:0] target_capacity;
		logic compaction_request;
		logic [CAP_W-1:0] capacity;
		logic at_max;
		logic [CNT_W-1:0] grow_count;
		logic [CNT_W-1:0] shrink_count;
		logic [CNT_W-1:0] compaction_count;
		logic [CAP_W-1:0] peak_capacity;
	} result_t;

	typedef struct packed {
		logic [CAP_W-1:0] initial_capacity;
		logic [CAP_W-1:0] max_capacity;
		logic [THR_W-1:0] grow_threshold;
		logic [THR_W-1:0] shrink_threshold;
		logic [FAC_W-1:0] grow_factor;
		logic [FAC_W-1:0] shrink_factor;
	} cfg_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

endpackage

// ----- src/tcgs_cfg.sv -----
// Configuration register file of the capacity policy block.
module tcgs_cfg
	import tcgs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0] cfg_data,
	output cfg_t             cfg,
	output logic             reload
);

	cfg_t cfg_q;
	logic reload_q;
	logic wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;
	assign cfg = cfg_q;
	// Writing the initial capacity also reloads the live capacity. The reload is
	// issued in the cycle after the write, once the new value sits in its register.
	assign reload = reload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_capacity <= INIT_CAP_RST;
			cfg_q.max_capacity <= MAX_CAP_RST;
			cfg_q.grow_threshold <= GROW_THR_RST;
			cfg_q.shrink_threshold <= SHRINK_THR_RST;
			cfg_q.grow_factor <= GROW_FAC_RST;
			cfg_q.shrink_factor <= SHRINK_FAC_RST;
			reload_q <= 1'b0;
		end else begin
			reload_q <= wr && (cfg_index == REG_INIT_CAP);
			if (wr) begin
				case (cfg_index)
					REG_INIT_CAP: cfg_q.initial_capacity <= cfg_data;
					REG_MAX_CAP: cfg_q.max_capacity <= cfg_data;
					REG_GROW_THR: cfg_q.grow_threshold <= cfg_data[THR_W-1:0];
					REG_SHRINK_THR: cfg_q.shrink_threshold <= cfg_data[THR_W-1:0];
					REG_GROW_FAC: cfg_q.grow_factor <= cfg_data[FAC_W-1:0];
					REG_SHRINK_FAC: cfg_q.shrink_factor <= cfg_data[FAC_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- src/tcgs_core.sv -----
// Grow and shrink decision logic together with the capacity and counter state.
module tcgs_core
	import tcgs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    reload,
	input  item_t   item,
	input  logic    advance,
	output result_t res
);

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] peak_q;
	logic [CNT_W-1:0] grows_q;
	logic [CNT_W-1:0] shrinks_q;
	logic [CNT_W-1:0] compacts_q;

	logic [CAP_W-1:0] cap_nx;
	logic [CAP_W-1:0] peak_nx;
	logic [CNT_W-1:0] grows_nx;
	logic [CNT_W-1:0] shrinks_nx;
	logic [CNT_W-1:0] compacts_nx;

	logic [33:0] live_sh;
	logic [32:0] grow_lim;
	logic [32:0] shrink_lim;
	logic grow_hit;
	logic shrink_hit;
	logic [31:0] grow_mul;
	logic [CAP_W-1:0] grow_tgt;
	logic [31:0] shrink_mul;
	logic [CAP_W-1:0] shrink_raw;
	logic [CAP_W-1:0] shrink_floor;
	logic [CAP_W:0] live_x2;
	logic [CAP_W:0] shrink_tgt;
	logic resized;
	logic compact;
	logic [CAP_W-1:0] target;

	always_comb begin
		// Usage ratios are compared as live*256 against threshold*capacity.
		live_sh = {2'b00, item.live_count, 8'h00};
		grow_lim = 33'(cfg.grow_threshold) * 33'(cap_q);
		shrink_lim = 33'(cfg.shrink_threshold) * 33'(cap_q);
		grow_hit = live_sh >= {1'b0, grow_lim};
		shrink_hit = (live_sh <= {1'b0, shrink_lim}) && (cap_q > cfg.initial_capacity);

		grow_mul = 32'(cap_q) * 32'(cfg.grow_factor);
		grow_tgt = (grow_mul[31:4] > 28'(cfg.max_capacity)) ? cfg.max_capacity
			: grow_mul[CAP_W+3:4];

		shrink_mul = 32'(cap_q) * 32'(cfg.shrink_factor);
		shrink_raw = shrink_mul[31:8];
		shrink_floor = (shrink_raw < cfg.initial_capacity) ? cfg.initial_capacity
			: shrink_raw;
		live_x2 = {item.live_count, 1'b0};
		shrink_tgt = ({1'b0, shrink_floor} < live_x2) ? live_x2 : {1'b0, shrink_floor};

		resized = 1'b0;
		compact = 1'b0;
		target = '0;
		cap_nx = cap_q;
		peak_nx = peak_q;
		grows_nx = grows_q;
		shrinks_nx = shrinks_q;
		compacts_nx = compacts_q;

		case (item.op)
			OP_GROW: begin
				if (grow_hit) begin
					if (grow_tgt <= cap_q) begin
						compact = 1'b1;
						compacts_nx = sat_inc(compacts_q);
					end else begin
						target = grow_tgt;
						if (item.resize_ok) begin
							cap_nx = grow_tgt;
							resized = 1'b1;
							grows_nx = sat_inc(grows_q);
						end
					end
				end
			end
			OP_SHRINK: begin
				if (shrink_hit && (shrink_tgt < {1'b0, cap_q})) begin
					target = shrink_tgt[CAP_W-1:0];
					if (item.resize_ok) begin
						cap_nx = shrink_tgt[CAP_W-1:0];
						resized = 1'b1;
						shrinks_nx = sat_inc(shrinks_q);
					end
				end
			end
			OP_PEAK: begin
				if (cap_q > peak_q) begin
					peak_nx = cap_q;
				end
			end
			default: ;
		endcase

		res.resized = resized;
		res.target_capacity = target;
		res.compaction_request = compact;
		res.capacity = cap_nx;
		res.at_max = cap_nx >= cfg.max_capacity;
		res.grow_count = grows_nx;
		res.shrink_count = shrinks_nx;
		res.compaction_count = compacts_nx;
		res.peak_capacity = peak_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= INIT_CAP_RST;
			peak_q <= '0;
			grows_q <= '0;
			shrinks_q <= '0;
			compacts_q <= '0;
		end else if (reload) begin
			cap_q <= cfg.initial_capacity;
		end else if (advance) begin
			cap_q <= cap_nx;
			peak_q <= peak_nx;
			grows_q <= grows_nx;
			shrinks_q <= shrinks_nx;
			compacts_q <= compacts_nx;
		end
	end

endmodule

// ----- src/table_capacity_grow_shrink_policy.sv -----
// Top level of the table capacity grow and shrink policy block.
//
//  channel  | direction | handshake              | beat
//  item     | in        | item_valid/item_stall  | op, live_count, resize_ok
//  result   | out       | result_valid/result_stall | decision, capacity, counters
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One item per cycle unless the result is stalled: an item is registered, decided
// against the capacity register, and its result beat is then registered.
// Result valid rises once the item has moved from the item register to the result register.
// A write to the initial capacity reloads capacity in the cycle after the write.
// Reset loads the register defaults and sets capacity to the initial capacity.
// A stalled result holds; one further item may still be taken behind it.
module table_capacity_grow_shrink_policy
	import tcgs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0] cfg_data
);

	cfg_t cfg;
	logic reload;
	logic item_valid_s1;
	item_t item_s1;
	logic result_valid_q;
	result_t result_q;
	result_t res;
	logic out_free;
	logic advance;

	assign out_free = !result_valid_q || !result_stall;
	assign advance = item_valid_s1 && out_free;
	assign item_stall = item_valid_s1 && !out_free;
	assign result_valid = result_valid_q;
	assign result = result_q;

	tcgs_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.reload(reload)
	);

	tcgs_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.reload(reload),
		.item(item_s1),
		.advance(advance),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				item_valid_s1 <= item_valid;
			end
			if (out_free) begin
				result_valid_q <= item_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= res;
		end
	end

endmodule

// ----- src/tcgs_checker.sv -----
// Port-level checker for the capacity policy block and its bind.
`include "table_capacity_grow_shrink_policy_assert.svh"

module tcgs_checker
	import tcgs_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A stalled item beat must stay put.
	`TCGS_ASSERT_NEXT(a_item_hold, item_valid && item_stall,
		item_valid && $stable(item))
	// A stalled result beat must stay put.
	`TCGS_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(result))
	// A resize lands exactly on the proposed target.
	`TCGS_ASSERT_NOW(a_resize_target, result_valid && result.resized,
		result.target_capacity == result.capacity)
	// A compaction request never comes with a proposed target or a resize, and is always counted.
	`TCGS_ASSERT_NOW(a_compact_excl, result_valid && result.compaction_request,
		!result.resized && result.target_capacity == '0 && result.compaction_count != '0)
	// Any resize has been counted.
	`TCGS_ASSERT_NOW(a_resize_counted, result_valid && result.resized,
		result.grow_count != '0 || result.shrink_count != '0)

endmodule

bind table_capacity_grow_shrink_policy tcgs_checker u_tcgs_checker (.*);

// ----- test/table_capacity_grow_shrink_policy_tb.sv -----
// Self-checking testbench of the table capacity grow and shrink policy block.
`timescale 1ns / 1ps

module table_capacity_grow_shrink_policy_tb;
	import tcgs_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
	localparam logic [CAP_W-1:0] CAP_ALL_ONES = {CAP_W{1'b1}};
	localparam int HOLD_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CAP_W-1:0] cfg_data = '0;

	table_capacity_grow_shrink_policy i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the policy registers and the capacity state.
	cfg_t policy;
	logic [CAP_W-1:0] track_cap;
	logic [CAP_W-1:0] track_peak;
	logic [CNT_W-1:0] grows_seen;
	logic [CNT_W-1:0] shrinks_seen;
	logic [CNT_W-1:0] compactions_seen;

	result_t pending_decisions[$];
	int error_count = 0;
	int results_checked = 0;
	int sender_idle_pct = 37;
	int receiver_idle_pct = 37;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] n);
		return (&n) ? n : n + 1'b1;
	endfunction

	function automatic result_t predict_decision(input item_t it);
		result_t r;
		logic [63:0] cap;
		logic [63:0] live;
		logic [63:0] tgt;
		r = '0;
		cap = 64'(track_cap);
		live = 64'(it.live_count);
		case (it.op)
			OP_GROW: begin
				if (live * 256 >= 64'(policy.grow_threshold) * cap) begin
					tgt = (cap * 64'(policy.grow_factor)) >> 4;
					if (tgt > 64'(policy.max_capacity))
						tgt = 64'(policy.max_capacity);
					if (tgt <= cap) begin
						r.compaction_request = 1'b1;
						compactions_seen = bump_sat(compactions_seen);
					end else begin
						r.target_capacity = tgt[CAP_W-1:0];
						if (it.resize_ok) begin
							track_cap = tgt[CAP_W-1:0];
							r.resized = 1'b1;
							grows_seen = bump_sat(grows_seen);
						end
					end
				end
			end
			OP_SHRINK: begin
				if (live * 256 <= 64'(policy.shrink_threshold) * cap &&
						cap > 64'(policy.initial_capacity)) begin
					tgt = (cap * 64'(policy.shrink_factor)) >> 8;
					if (tgt < 64'(policy.initial_capacity))
						tgt = 64'(policy.initial_capacity);
					if (tgt < live * 2)
						tgt = live * 2;
					if (tgt < cap) begin
						r.target_capacity = tgt[CAP_W-1:0];
						if (it.resize_ok) begin
							track_cap = tgt[CAP_W-1:0];
							r.resized = 1'b1;
							shrinks_seen = bump_sat(shrinks_seen);
						end
					end
				end
			end
			OP_PEAK: begin
				if (track_cap > track_peak)
					track_peak = track_cap;
			end
			default: begin
			end
		endcase
		r.capacity = track_cap;
		r.at_max = (track_cap >= policy.max_capacity);
		r.grow_count = grows_seen;
		r.shrink_count = shrinks_seen;
		r.compaction_count = compactions_seen;
		r.peak_capacity = track_peak;
		return r;
	endfunction

	function automatic item_t make_item(input logic [OP_W-1:0] op, input logic [CAP_W-1:0] live,
			input logic ok);
		item_t it;
		it.op = op;
		it.live_count = live;
		it.resize_ok = ok;
		return it;
	endfunction

	// Live counts are aimed mostly at the two threshold boundaries of the current capacity.
	function automatic item_t random_item();
		longint g;
		longint s;
		longint v;
		int pick;
		logic [OP_W-1:0] op;
		g = longint'((64'(policy.grow_threshold) * 64'(track_cap)) >> 8);
		s = longint'((64'(policy.shrink_threshold) * 64'(track_cap)) >> 8);
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = longint'(CAP_ALL_ONES);
			2: v = longint'($urandom_range(0, CAP_ALL_ONES));
			3, 4, 5: v = g + longint'($urandom_range(0, 4)) - 2;
			6, 7, 8: v = s - longint'($urandom_range(0, 32'(s / 2)));
			default: v = longint'($urandom_range(0, 32'(track_cap)));
		endcase
		if (v < 0)
			v = 0;
		if (v > longint'(CAP_ALL_ONES))
			v = longint'(CAP_ALL_ONES);
		pick = $urandom_range(0, 99);
		if (pick < 42)
			op = OP_GROW;
		else if (pick < 84)
			op = OP_SHRINK;
		else if (pick < 96)
			op = OP_PEAK;
		else
			op = OP_UNUSED;
		return make_item(op, v[CAP_W-1:0], $urandom_range(0, 99) < 80);
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		pending_decisions.push_back(predict_decision(it));
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CAP_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_INIT_CAP: begin
				policy.initial_capacity = data;
				track_cap = data;
			end
			REG_MAX_CAP: policy.max_capacity = data;
			REG_GROW_THR: policy.grow_threshold = data[THR_W-1:0];
			REG_SHRINK_THR: policy.shrink_threshold = data[THR_W-1:0];
			REG_GROW_FAC: policy.grow_factor = data[FAC_W-1:0];
			REG_SHRINK_FAC: policy.shrink_factor = data[FAC_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		wait_idle();
		write_register(REG_MAX_CAP, c.max_capacity);
		write_register(REG_GROW_THR, CAP_W'(c.grow_threshold));
		write_register(REG_SHRINK_THR, CAP_W'(c.shrink_threshold));
		write_register(REG_GROW_FAC, CAP_W'(c.grow_factor));
		write_register(REG_SHRINK_FAC, CAP_W'(c.shrink_factor));
		write_register(REG_INIT_CAP, c.initial_capacity);
	endtask

	function automatic cfg_t default_config();
		cfg_t c;
		c.initial_capacity = INIT_CAP_RST;
		c.max_capacity = MAX_CAP_RST;
		c.grow_threshold = GROW_THR_RST;
		c.shrink_threshold = SHRINK_THR_RST;
		c.grow_factor = GROW_FAC_RST;
		c.shrink_factor = SHRINK_FAC_RST;
		return c;
	endfunction

	task automatic note_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		error_count++;
		if (error_count <= 10)
			$display("result %0d: %s expected %0h, got %0h", results_checked, field, want, got);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_decisions.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("result beat with no decision pending: %h", got);
			return;
		end
		want = pending_decisions.pop_front();
		if (got.resized !== want.resized)
			note_mismatch("resized", 64'(want.resized), 64'(got.resized));
		if (got.target_capacity !== want.target_capacity)
			note_mismatch("target_capacity", 64'(want.target_capacity),
				64'(got.target_capacity));
		if (got.compaction_request !== want.compaction_request)
			note_mismatch("compaction_request", 64'(want.compaction_request),
				64'(got.compaction_request));
		if (got.capacity !== want.capacity)
			note_mismatch("capacity", 64'(want.capacity), 64'(got.capacity));
		if (got.at_max !== want.at_max)
			note_mismatch("at_max", 64'(want.at_max), 64'(got.at_max));
		if (got.grow_count !== want.grow_count)
			note_mismatch("grow_count", 64'(want.grow_count), 64'(got.grow_count));
		if (got.shrink_count !== want.shrink_count)
			note_mismatch("shrink_count", 64'(want.shrink_count), 64'(got.shrink_count));
		if (got.compaction_count !== want.compaction_count)
			note_mismatch("compaction_count", 64'(want.compaction_count),
				64'(got.compaction_count));
		if (got.peak_capacity !== want.peak_capacity)
			note_mismatch("peak_capacity", 64'(want.peak_capacity),
				64'(got.peak_capacity));
		results_checked++;
	endtask

	// Result side: check each accepted beat, then choose the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			check_result(result);
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic test_directed_ops();
		send_item(make_item(OP_PEAK, '0, 1'b1));
		send_item(make_item(OP_GROW, '0, 1'b1));
		// A refused grow still reports its target.
		send_item(make_item(OP_GROW, 24'd60000, 1'b0));
		send_item(make_item(OP_GROW, 24'd60000, 1'b1));
		send_item(make_item(OP_GROW, CAP_ALL_ONES, 1'b1));
		// At the maximum a grow turns into a compaction request.
		send_item(make_item(OP_GROW, CAP_ALL_ONES, 1'b1));
		send_item(make_item(OP_PEAK, CAP_ALL_ONES, 1'b0));
		send_item(make_item(OP_SHRINK, '0, 1'b0));
		send_item(make_item(OP_SHRINK, '0, 1'b1));
		send_item(make_item(OP_SHRINK, 24'd30000, 1'b1));
		// Capacity is at the floor now, so no shrink is proposed.
		send_item(make_item(OP_SHRINK, '0, 1'b1));
		send_item(make_item(OP_UNUSED, CAP_ALL_ONES, 1'b1));
		send_item(make_item(OP_GROW, 24'h800000, 1'b1));
		send_item(make_item(OP_SHRINK, 24'd40000, 1'b1));
		send_item(make_item(OP_SHRINK, CAP_ALL_ONES, 1'b1));
		send_item(make_item(OP_UNUSED, '0, 1'b0));
		send_item(make_item(OP_PEAK, 24'h555555, 1'b1));
	endtask

	task automatic test_register_writes();
		cfg_t c;
		// A zero initial capacity leaves capacity at zero.
		c = default_config();
		c.initial_capacity = '0;
		apply_config(c);
		send_item(make_item(OP_GROW, '0, 1'b1));
		send_item(make_item(OP_SHRINK, '0, 1'b1));
		send_item(make_item(OP_PEAK, CAP_ALL_ONES, 1'b1));
		// Writes to unmapped indexes must leave every register alone.
		apply_config(default_config());
		write_register(REG_UNMAPPED_LO, CAP_ALL_ONES);
		write_register(REG_UNMAPPED_HI, '0);
		send_item(make_item(OP_GROW, 24'd70000, 1'b1));
		send_item(make_item(OP_SHRINK, 24'd1, 1'b1));
	endtask

	task automatic test_backpressure();
		sender_idle_pct = 0;
		hold_req = 1'b1;
		repeat (30) send_item(random_item());
		sender_idle_pct = 37;
	endtask

	task automatic test_sender_pause();
		repeat (20) send_item(random_item());
		item_valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (20) send_item(random_item());
	endtask

	task automatic test_random_sweep();
		cfg_t c;
		for (int phase = 0; phase < 6; phase++) begin
			c = default_config();
			case (phase)
				0: begin
				end
				1: begin
					c.initial_capacity = 24'd1;
					c.max_capacity = CAP_ALL_ONES;
					c.grow_threshold = '0;
					c.shrink_threshold = 9'd256;
					c.grow_factor = 8'd255;
					c.shrink_factor = '0;
				end
				2: begin
					c.initial_capacity = CAP_ALL_ONES;
					c.max_capacity = 24'd1;
					c.grow_threshold = 9'd256;
					c.shrink_threshold = '0;
					c.grow_factor = 8'd16;
					c.shrink_factor = 8'd255;
				end
				default: begin
					c.initial_capacity = CAP_W'($urandom_range(1, 1 << 16));
					c.max_capacity = CAP_W'($urandom_range(1, CAP_ALL_ONES));
					c.grow_threshold = THR_W'($urandom_range(0, 256));
					c.shrink_threshold = THR_W'($urandom_range(0, 256));
					c.grow_factor = FAC_W'($urandom_range(16, 255));
					c.shrink_factor = FAC_W'($urandom_range(0, 255));
				end
			endcase
			apply_config(c);
			// One phase runs with no idling on either side.
			if (phase == 3) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			repeat (210) send_item(random_item());
			sender_idle_pct = 37;
			receiver_idle_pct = 37;
		end
	endtask

	initial begin
		policy = default_config();
		track_cap = INIT_CAP_RST;
		track_peak = '0;
		grows_seen = '0;
		shrinks_seen = '0;
		compactions_seen = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_register_writes();
		apply_config(default_config());
		test_backpressure();
		test_sender_pause();
		test_random_sweep();
		wait_idle();
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- table_capacity_grow_shrink_policy.f -----
+incdir+src
src/tcgs_pkg.sv
src/tcgs_cfg.sv
src/tcgs_core.sv
src/table_capacity_grow_shrink_policy.sv
src/tcgs_checker.sv
test/table_capacity_grow_shrink_policy_tb.sv
